[sv/udt_pkg.sv]
package udt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_MINUS   = 3'd4,
    MODE_INT     = 3'd5,
    MODE_FRAC    = 3'd6,
    MODE_IDENT   = 3'd7
  } mode_t;

  localparam int KW_COUNT = 40;
  localparam int KW_MAXLEN = 18;

  localparam logic [5:0] KIND_EOF    = 6'd0;
  localparam logic [5:0] KIND_IDENT  = 6'd1;
  localparam logic [5:0] KIND_INT    = 6'd2;
  localparam logic [5:0] KIND_FLOAT  = 6'd3;
  localparam logic [5:0] KIND_STRING = 6'd4;
  localparam logic [5:0] KIND_BOOL   = 6'd5;
  localparam logic [5:0] KIND_ERROR  = 6'd6;
  localparam logic [5:0] KIND_OP0    = 6'd7;

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // one result record
  typedef struct packed {
    logic        record_kind;
    logic [7:0]  text_byte;
    logic [5:0]  token_kind;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        unterminated;
    logic        last;
  } rec_t;

  // up to four records produced by one input beat
  typedef struct packed {
    logic [2:0]     count;
    rec_t [3:0]     recs;
  } bundle_t;

  typedef logic [KW_MAXLEN*8-1:0] spell_t;

  function automatic spell_t kw_spell(input int i);
    string s;
    spell_t r;
    case (i)
      0: s = "module";           1: s = "end";             2: s = "procedure";
      3: s = "object";           4: s = "value";           5: s = "list";
      6: s = "include";          7: s = "arguments";       8: s = "callbacks";
      9: s = "controls";         10: s = "identifier";     11: s = "integer";
      12: s = "boolean";         13: s = "float";          14: s = "string";
      15: s = {string'("compound"), "_string"};
      16: s = {string'("font"), "_table"};
      17: s = "font";
      18: s = "color";           19: s = "pixmap";         20: s = "icon";
      21: s = "reason";          22: s = "argument";
      23: s = {string'("translation"), "_table"};
      24: s = "keysym";
      25: s = {string'("character"), "_set"};
      26: s = "names";
      27: s = {string'("case"), "_sensitive"};
      28: s = {string'("case"), "_insensitive"};
      29: s = "version";
      30: s = "managed";         31: s = "unmanaged";      32: s = "private";
      33: s = "exported";        34: s = "imported";       35: s = "separate";
      36: s = "true";            37: s = "false";          38: s = "on";
      default: s = "off";
    endcase
    r = '0;
    for (int k = 0; k < KW_MAXLEN; k++) begin
      if (k < s.len()) r[k*8 +: 8] = s[k];
    end
    return r;
  endfunction

  function automatic logic [4:0] kw_len(input int i);
    spell_t s;
    logic [4:0] n;
    s = kw_spell(i);
    n = '0;
    for (int k = 0; k < KW_MAXLEN; k++) begin
      if (s[k*8 +: 8] != 8'h00) n = n + 5'd1;
    end
    return n;
  endfunction

  function automatic logic [5:0] kw_kind(input int i);
    logic [5:0] r;
    if (i == 36 || i == 37) r = KIND_BOOL;
    else if (i > 37) r = 6'(i + 19);
    else r = 6'(i + 21);
    return r;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] b);
    logic [5:0] r;
    case (b)
      8'h3D: r = KIND_OP0;
      8'h3B: r = KIND_OP0 + 6'd1;
      8'h3A: r = KIND_OP0 + 6'd2;
      8'h2C: r = KIND_OP0 + 6'd3;
      8'h7B: r = KIND_OP0 + 6'd4;
      8'h7D: r = KIND_OP0 + 6'd5;
      8'h28: r = KIND_OP0 + 6'd6;
      8'h29: r = KIND_OP0 + 6'd7;
      8'h26: r = KIND_OP0 + 6'd8;
      8'h2B: r = KIND_OP0 + 6'd9;
      8'h2A: r = KIND_OP0 + 6'd10;
      8'h2F: r = KIND_OP0 + 6'd11;
      8'h7E: r = KIND_OP0 + 6'd12;
      8'h23: r = KIND_OP0 + 6'd13;
      default: r = KIND_ERROR;
    endcase
    return r;
  endfunction

endpackage

[sv/udt_if.sv]
interface udt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;
  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface udt_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  text_byte;
  logic [5:0]  token_kind;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        unterminated;
  logic        last;
  modport source (output valid, record_kind, text_byte, token_kind, line_number,
                  column_number, unterminated, last, input ready);
  modport sink (input valid, record_kind, text_byte, token_kind, line_number,
                column_number, unterminated, last, output ready);
endinterface

[sv/udt_front.sv]
module udt_front import udt_pkg::*; #(
  parameter int COUNTER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] source_byte,
  input  logic       end_of_source,
  output logic       push,
  output bundle_t    push_data,
  input  logic       full
);

  localparam logic [COUNTER_BITS-1:0] TOP = '1;
  localparam logic [COUNTER_BITS-1:0] ONE = COUNTER_BITS'(1);

  mode_t                   mode, mode_next;
  logic                    acr, acr_next;
  logic [COUNTER_BITS-1:0] line_cnt, line_next;
  logic [COUNTER_BITS-1:0] col_cnt, col_next;
  logic [KW_COUNT-1:0]     cand, cand_next;
  logic [4:0]              wlen, wlen_next;

  logic       fire;
  logic [7:0] b, lb;
  logic       is_dig, is_alp, is_wrd;
  logic [5:0] id_kind;
  logic [KW_COUNT-1:0] nar;

  assign in_ready = !full;
  assign fire = in_valid && in_ready;
  assign b = source_byte;
  assign is_dig = b >= 8'h30 && b <= 8'h39;
  assign is_alp = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  assign is_wrd = is_alp || is_dig || b == 8'h5F;
  assign lb = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;

  function automatic logic [COUNTER_BITS-1:0] sat(input logic [COUNTER_BITS-1:0] v);
    return (v < TOP) ? v + ONE : v;
  endfunction

  // match the current word against the keyword table
  always_comb begin
    id_kind = KIND_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (cand[i] && kw_len(i) == wlen) id_kind = kw_kind(i);
    end
  end

  // candidates surviving the next character at position wlen
  always_comb begin
    spell_t s;
    for (int i = 0; i < KW_COUNT; i++) begin
      s = kw_spell(i);
      nar[i] = (wlen < kw_len(i)) && (s[wlen*8 +: 8] == lb);
    end
  end

  always_comb begin
    logic [2:0] n;
    logic       rescan;
    logic [5:0] ckind;
    rec_t       r;
    spell_t     sp;
    mode_next = mode;
    acr_next = acr;
    line_next = line_cnt;
    col_next = col_cnt;
    cand_next = cand;
    wlen_next = wlen;
    push_data = '0;
    n = '0;
    rescan = 1'b0;
    ckind = KIND_ERROR;
    r = '0;
    sp = '0;

    if (end_of_source) begin
      case (mode)
        MODE_STRING: begin
          push_data.recs[n[1:0]] = '{1'b1, 8'h00, KIND_STRING, 16'(line_cnt), 16'(col_cnt),
                                     1'b1, 1'b0};
          n = n + 3'd1;
        end
        MODE_ESCAPE: begin
          push_data.recs[n[1:0]] = '{1'b0, CH_BSLASH, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
          n = n + 3'd1;
          push_data.recs[n[1:0]] = '{1'b1, 8'h00, KIND_STRING, 16'(line_cnt), 16'(col_cnt),
                                     1'b1, 1'b0};
          n = n + 3'd1;
        end
        MODE_MINUS: begin
          push_data.recs[n[1:0]] = '{1'b0, CH_MINUS, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
          n = n + 3'd1;
          push_data.recs[n[1:0]] = '{1'b1, 8'h00, KIND_ERROR, 16'(line_cnt), 16'(col_cnt),
                                     1'b0, 1'b0};
          n = n + 3'd1;
        end
        MODE_INT, MODE_FRAC, MODE_IDENT: begin
          ckind = (mode == MODE_INT) ? KIND_INT :
                  (mode == MODE_FRAC) ? KIND_FLOAT : id_kind;
          push_data.recs[n[1:0]] = '{1'b1, 8'h00, ckind, 16'(line_cnt), 16'(col_cnt),
                                     1'b0, 1'b0};
          n = n + 3'd1;
        end
        default: ;
      endcase
      push_data.recs[n[1:0]] = '{1'b1, 8'h00, KIND_EOF, 16'(line_cnt), 16'(col_cnt),
                                 1'b0, 1'b0};
      n = n + 3'd1;
      mode_next = MODE_IDLE;
      acr_next = 1'b0;
      line_next = ONE;
      col_next = ONE;
      cand_next = '0;
      wlen_next = '0;
    end else begin
      case (mode)
        MODE_COMMENT: begin
          if (b == CH_LF) begin
            mode_next = MODE_IDLE;
            rescan = 1'b1;
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            col_next = sat(col_cnt);
            push_data.recs[n[1:0]] = '{1'b1, 8'h00, KIND_STRING, 16'(line_cnt),
                                       16'(col_next), 1'b0, 1'b0};
            n = n + 3'd1;
            mode_next = MODE_IDLE;
          end else if (b == CH_BSLASH) begin
            col_next = sat(col_cnt);
            mode_next = MODE_ESCAPE;
          end else if (b == CH_LF) begin
            push_data.recs[n[1:0]] = '{1'b0, b, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
            n = n + 3'd1;
            line_next = sat(line_cnt);
            col_next = ONE;
          end else begin
            push_data.recs[n[1:0]] = '{1'b0, b, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
            n = n + 3'd1;
            col_next = sat(col_cnt);
          end
        end
        MODE_ESCAPE: begin
          push_data.recs[n[1:0]] = '{1'b0, (b == 8'h6E) ? 8'd10 : ((b == 8'h74) ? 8'd9 : b),
                                     6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
          n = n + 3'd1;
          col_next = sat(col_cnt);
          mode_next = MODE_STRING;
        end
        MODE_MINUS: begin
          push_data.recs[n[1:0]] = '{1'b0, CH_MINUS, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
          n = n + 3'd1;
          if (is_dig) begin
            push_data.recs[n[1:0]] = '{1'b0, b, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
            n = n + 3'd1;
            col_next = sat(col_cnt);
            mode_next = MODE_INT;
          end else begin
            ckind = KIND_ERROR;
            rescan = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_dig || b == CH_DOT) begin
            push_data.recs[n[1:0]] = '{1'b0, b, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
            n = n + 3'd1;
            col_next = sat(col_cnt);
            if (b == CH_DOT) mode_next = MODE_FRAC;
          end else begin
            ckind = KIND_INT;
            rescan = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_dig) begin
            push_data.recs[n[1:0]] = '{1'b0, b, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
            n = n + 3'd1;
            col_next = sat(col_cnt);
          end else begin
            ckind = KIND_FLOAT;
            rescan = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_wrd) begin
            push_data.recs[n[1:0]] = '{1'b0, b, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
            n = n + 3'd1;
            col_next = sat(col_cnt);
            cand_next = cand & nar;
            if (wlen < 5'd31) wlen_next = wlen + 5'd1;
          end else begin
            ckind = id_kind;
            rescan = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      // close the open token before rescanning this byte from idle
      if (rescan && mode != MODE_IDLE && mode != MODE_COMMENT) begin
        push_data.recs[n[1:0]] = '{1'b1, 8'h00, ckind, 16'(line_cnt), 16'(col_cnt),
                                   1'b0, 1'b0};
        n = n + 3'd1;
        mode_next = MODE_IDLE;
      end

      // idle scan of the byte
      if (rescan) begin
        if (acr && b == CH_LF) begin
          acr_next = 1'b0;
        end else if (b == CH_LF || b == CH_CR) begin
          line_next = sat(line_cnt);
          col_next = ONE;
          acr_next = (b == CH_CR);
        end else begin
          acr_next = 1'b0;
          if (b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C) begin
            col_next = sat(col_cnt);
          end else if (b == CH_BANG) begin
            mode_next = MODE_COMMENT;
          end else begin
            col_next = sat(col_cnt);
            if (b == CH_QUOTE) begin
              mode_next = MODE_STRING;
            end else if (is_dig) begin
              push_data.recs[n[1:0]] = '{1'b0, b, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
              n = n + 3'd1;
              mode_next = MODE_INT;
            end else if (b == CH_MINUS) begin
              mode_next = MODE_MINUS;
            end else if (is_alp || b == 8'h5F) begin
              push_data.recs[n[1:0]] = '{1'b0, b, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
              n = n + 3'd1;
              mode_next = MODE_IDENT;
              for (int i = 0; i < KW_COUNT; i++) begin
                sp = kw_spell(i);
                cand_next[i] = (kw_len(i) > 5'd0) && (sp[7:0] == lb);
              end
              wlen_next = 5'd1;
            end else begin
              push_data.recs[n[1:0]] = '{1'b0, b, 6'd0, 16'd0, 16'd0, 1'b0, 1'b0};
              n = n + 3'd1;
              push_data.recs[n[1:0]] = '{1'b1, 8'h00, op_kind(b), 16'(line_cnt),
                                         16'(col_next), 1'b0, 1'b0};
              n = n + 3'd1;
            end
          end
        end
      end
    end

    // mark the final record of this beat
    if (n != 3'd0) begin
      r = push_data.recs[2'(n - 3'd1)];
      r.last = 1'b1;
      push_data.recs[2'(n - 3'd1)] = r;
    end
    push_data.count = n;
  end

  assign push = fire && push_data.count != 3'd0;

  // advance scanner state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      acr <= 1'b0;
      line_cnt <= ONE;
      col_cnt <= ONE;
      cand <= '0;
      wlen <= '0;
    end else if (fire) begin
      mode <= mode_next;
      acr <= acr_next;
      line_cnt <= line_next;
      col_cnt <= col_next;
      cand <= cand_next;
      wlen <= wlen_next;
    end
  end

endmodule

[sv/udt_queue.sv]
module udt_queue import udt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  output logic    pop_valid,
  output bundle_t pop_data,
  input  logic    pop
);

  bundle_t    slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign pop_valid = fill != 2'd0;
  assign pop_data = slots[rd_ptr];

  // hold bundles between scanner and serializer
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[sv/udt_back.sv]
module udt_back import udt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  bundle_t q_data,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output rec_t    out_rec
);

  logic [1:0] idx;
  logic       send;

  assign out_valid = q_valid;
  assign out_rec = q_data.recs[idx];
  assign send = out_valid && out_ready;
  assign pop = send && ({1'b0, idx} + 3'd1 == q_data.count);

  // step through the records of the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop) begin
      idx <= '0;
    end else if (send) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

[sv/ui_description_tokenizer.sv]
// Streaming tokenizer: one source byte (or end marker) is accepted per cycle
// while the queue has room; each beat yields zero to four records that leave
// one per cycle while the output is ready. The scanner classifies each byte
// and writes its records as one bundle into a two-entry queue; the serializer
// sends records one at a time, so sustained input rate is one byte per cycle
// while the output keeps up, and bursts of multi-record bytes (token closes,
// operators, end of input) throttle input to the output record rate.
module ui_description_tokenizer import udt_pkg::*; #(
  parameter int COUNTER_BITS = 16
) (
  input logic clk,
  input logic rst,
  udt_in_if.sink    in_ch,
  udt_out_if.source out_ch
);

  logic    push, full, q_valid, pop;
  bundle_t push_data, q_data;
  rec_t    rec;

  udt_front #(.COUNTER_BITS(COUNTER_BITS)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .source_byte(in_ch.source_byte), .end_of_source(in_ch.end_of_source),
    .push, .push_data, .full
  );

  udt_queue u_queue (
    .clk, .rst, .push, .push_data, .full,
    .pop_valid(q_valid), .pop_data(q_data), .pop
  );

  udt_back u_back (
    .clk, .rst, .q_valid, .q_data, .pop,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rec(rec)
  );

  assign out_ch.record_kind = rec.record_kind;
  assign out_ch.text_byte = rec.text_byte;
  assign out_ch.token_kind = rec.token_kind;
  assign out_ch.line_number = rec.line_number;
  assign out_ch.column_number = rec.column_number;
  assign out_ch.unterminated = rec.unterminated;
  assign out_ch.last = rec.last;

  // an end-of-file beat always produces a record
  a_eof_push: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.end_of_source) |-> push)
    else $error("end marker produced no records");

  // a bundle leaves only on its last record
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |-> out_ch.last)
    else $error("bundle popped before its last record");

  // text records carry no position
  a_text_clean: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.record_kind) |-> (out_ch.line_number == 16'd0))
    else $error("text record with position");

endmodule
